// ----- src/raised_cosine_motion_profile_defines.svh -----
// ----------------------------------------------------------------------------
// Raised-cosine motion profile: assertion macros
// Clocked property checks, reset-qualified or not, used by the profile shaper.
// ----------------------------------------------------------------------------
`ifndef RAISED_COSINE_MOTION_PROFILE_DEFINES_SVH
`define RAISED_COSINE_MOTION_PROFILE_DEFINES_SVH

`ifndef SYNTHESIS
// checked on clk_i, off while rst_ni is low
`define RCMP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
// checked on clk_i, also during reset
`define RCMP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define RCMP_ASSERT(lbl, prop, msg)
`define RCMP_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- src/rcmp_pkg.sv -----
// ----------------------------------------------------------------------------
// Raised-cosine motion profile package
// Widths, fixed-point constants, register and status codes.
// ----------------------------------------------------------------------------
package rcmp_pkg;

  localparam int TW     = 32;            // time stamp width
  localparam int FB     = 16;            // fraction bits
  localparam int DUR_W  = 20;
  localparam int DLY_W  = 16;
  localparam int SPAN_W = DUR_W + 2;     // signed span
  localparam int ADDR_W = 5;

  localparam logic [FB:0] ONE = {1'b1, {FB{1'b0}}};

  // Q1.30 coefficients of sin(pi/2 x)
  localparam logic [30:0] CA = 31'd1686629713;
  localparam logic [30:0] CB = 31'd693598668;
  localparam logic [30:0] CC = 31'd85569306;
  localparam logic [30:0] CD = 31'd5026995;
  localparam logic [30:0] CE = 31'd172272;

  typedef enum logic [2:0] {
    REG_SHAPE = 3'd0,
    REG_MAG   = 3'd1,
    REG_START = 3'd2,
    REG_DUR   = 3'd3,
    REG_LEAD  = 3'd4,
    REG_TRAIL = 3'd5
  } reg_idx_e;

  typedef enum logic [2:0] {
    SH_FALL = 3'd0,   // half 1+cos fall
    SH_QCOS = 3'd1,   // quarter 1-cos rise
    SH_QSIN = 3'd2,   // quarter sin rise
    SH_HCOS = 3'd3,   // half 1-cos rise
    SH_FULL = 3'd4,   // full 1-cos pulse
    SH_HSIN = 3'd5    // half sin pulse
  } shape_e;

  typedef enum logic [1:0] {
    PH_BEFORE = 2'd0,
    PH_RAMP   = 2'd1,
    PH_AFTER  = 2'd2,
    PH_BAD    = 2'd3
  } phase_e;

endpackage

// ----- src/raised_cosine_motion_profile.sv -----
// ----------------------------------------------------------------------------
// Raised-cosine motion profile shaper
// Maps a time stamp onto a configured ramp window and returns a shaped value.
// ----------------------------------------------------------------------------
// Usage:
//  - Config over APB: shape, magnitude, start, duration, lead and trail
//    delay at byte addresses 0,4,..,20. Write only while the stream is idle.
//  - Slave stream: one time stamp per beat in s_axis_tdata_i.
//  - Master stream: profile value (Q16.16) and phase status per beat.
//  - Throughput: one beat per cycle while result beats are taken.
//    The critical stages are the 16 one-bit divider steps and the 31x31
//    multiply of each polynomial stage.
//  - The whole pipeline advances together; when m_axis_tready_i is low with
//    a result waiting, every stage holds and s_axis_tready_o drops, so no
//    beat is lost or repeated.
//  - Reset clears all valid bits and all config registers to zero.
// Pipeline: input reg, window compare, 16 divider steps, angle fold,
// square, 4 Horner steps, final product, round/shape, magnitude multiply,
// output.
// ----------------------------------------------------------------------------
`include "raised_cosine_motion_profile_defines.svh"

module raised_cosine_motion_profile (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid_i,
  output logic                        s_axis_tready_o,
  input  logic [31:0]                 s_axis_tdata_i,  // [31:0] time_now
  output logic                        m_axis_tvalid_o,
  input  logic                        m_axis_tready_i,
  output logic [39:0]                 m_axis_tdata_o,  // [31:0] profile_value,
                                                       // [33:32] phase_status
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [rcmp_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  output logic [31:0]                 prdata_o,
  output logic                        pready_o
);
  import rcmp_pkg::*;

  localparam int ST_DIV = 2;          // first divider stage
  localparam int ST_A   = ST_DIV + FB;
  localparam int ST_B   = ST_A + 1;
  localparam int ST_P   = ST_B + 1;   // four Horner stages
  localparam int ST_S   = ST_P + 4;
  localparam int ST_R   = ST_S + 1;
  localparam int ST_M   = ST_R + 1;
  localparam int NST    = ST_M + 2;   // output stage is NST-1

  localparam logic [30:0] COEF [4] = '{CD, CC, CB, CA};

  // ---------------- configuration ----------------
  logic [2:0]       shape_q;
  logic [31:0]      mag_q;
  logic [TW-1:0]    start_q;
  logic [DUR_W-1:0] dur_q;
  logic [DLY_W-1:0] lead_q;
  logic [DLY_W-1:0] trail_q;
  logic             cfg_wr;

  assign cfg_wr   = psel_i & penable_i & pwrite_i;
  assign pready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= '0;
      mag_q   <= '0;
      start_q <= '0;
      dur_q   <= '0;
      lead_q  <= '0;
      trail_q <= '0;
    end else if (cfg_wr) begin
      case (reg_idx_e'(paddr_i[4:2]))
        REG_SHAPE: shape_q <= pwdata_i[2:0];
        REG_MAG:   mag_q   <= pwdata_i;
        REG_START: start_q <= pwdata_i[TW-1:0];
        REG_DUR:   dur_q   <= pwdata_i[DUR_W-1:0];
        REG_LEAD:  lead_q  <= pwdata_i[DLY_W-1:0];
        REG_TRAIL: trail_q <= pwdata_i[DLY_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx_e'(paddr_i[4:2]))
      REG_SHAPE: prdata_o = {29'd0, shape_q};
      REG_MAG:   prdata_o = mag_q;
      REG_START: prdata_o = start_q;
      REG_DUR:   prdata_o = {{(32-DUR_W){1'b0}}, dur_q};
      REG_LEAD:  prdata_o = {{(32-DLY_W){1'b0}}, lead_q};
      REG_TRAIL: prdata_o = {{(32-DLY_W){1'b0}}, trail_q};
      default:   prdata_o = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic   en;
  logic   vld_q [0:NST-1];
  phase_e ph_q  [1:NST-1];
  phase_e ph_d;

  assign en              = !vld_q[NST-1] || m_axis_tready_i;
  assign s_axis_tready_o = en;
  assign m_axis_tvalid_o = vld_q[NST-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NST; k++) vld_q[k] <= 1'b0;
    end else if (en) begin
      vld_q[0] <= s_axis_tvalid_i;
      for (int k = 1; k < NST; k++) vld_q[k] <= vld_q[k-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q[1] <= ph_d;
      for (int k = 2; k < NST; k++) ph_q[k] <= ph_q[k-1];
    end
  end

  // ---------------- stage 0: input register ----------------
  logic [TW-1:0] t_q;
  always_ff @(posedge clk_i) begin
    if (en) t_q <= s_axis_tdata_i[TW-1:0];
  end

  // ---------------- stage 1: window compare ----------------
  logic signed [SPAN_W-1:0] endo, span;
  logic [DUR_W-1:0] span_u;
  logic [TW-1:0]    rel, el;
  logic             early, lt_lead, le_lead, lt_end, le_end;
  logic             rising, pre_ramp, in_ramp, span_np, fone_d;

  assign endo   = $signed({2'b00, dur_q}) - $signed({{(SPAN_W-DLY_W){1'b0}}, trail_q});
  assign span   = endo - $signed({{(SPAN_W-DLY_W){1'b0}}, lead_q});
  assign span_u = span[DUR_W-1:0];
  assign span_np = span[SPAN_W-1] || (span == '0);

  assign early   = t_q < start_q;
  assign rel     = t_q - start_q;
  assign lt_lead = early || (rel <  {{(TW-DLY_W){1'b0}}, lead_q});
  assign le_lead = early || (rel <= {{(TW-DLY_W){1'b0}}, lead_q});
  // endo is at most 2^DUR_W - 1 when non-negative
  assign lt_end  = early || (!endo[SPAN_W-1] && (endo != '0) &&
                   (rel <  {{(TW-DUR_W){1'b0}}, endo[DUR_W-1:0]}));
  assign le_end  = early || (!endo[SPAN_W-1] &&
                   (rel <= {{(TW-DUR_W){1'b0}}, endo[DUR_W-1:0]}));
  assign el      = rel - {{(TW-DLY_W){1'b0}}, lead_q};
  assign fone_d  = span_np || (el >= {{(TW-DUR_W){1'b0}}, span_u});

  always_comb begin
    rising   = (shape_q == SH_QCOS) || (shape_q == SH_QSIN) || (shape_q == SH_HCOS);
    pre_ramp = rising ? lt_lead : le_lead;
    in_ramp  = ((shape_q == SH_FALL) || (shape_q == SH_HSIN)) ? lt_end : le_end;
    if (shape_q > SH_HSIN) ph_d = PH_BAD;
    else if (pre_ramp)     ph_d = PH_BEFORE;
    else if (in_ramp)      ph_d = PH_RAMP;
    else                   ph_d = PH_AFTER;
  end

  // ---------------- divider: one quotient bit per stage ----------------
  logic [DUR_W-1:0] dv_rem_q [0:FB];
  logic [FB-1:0]    dv_quo_q [0:FB];
  logic             dv_one_q [0:FB];
  logic [DUR_W:0]   dv_sh    [0:FB-1];
  logic             dv_ge    [0:FB-1];
  logic [DUR_W:0]   dv_sub   [0:FB-1];

  always_comb begin
    for (int i = 0; i < FB; i++) begin
      dv_sh[i]  = {dv_rem_q[i], 1'b0};
      dv_ge[i]  = dv_sh[i] >= {1'b0, span_u};
      dv_sub[i] = dv_sh[i] - {1'b0, span_u};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dv_rem_q[0] <= el[DUR_W-1:0];
      dv_quo_q[0] <= '0;
      dv_one_q[0] <= fone_d;
      for (int i = 0; i < FB; i++) begin
        dv_rem_q[i+1] <= dv_ge[i] ? dv_sub[i][DUR_W-1:0] : dv_sh[i][DUR_W-1:0];
        dv_quo_q[i+1] <= {dv_quo_q[i][FB-2:0], dv_ge[i]};
        dv_one_q[i+1] <= dv_one_q[i];
      end
    end
  end

  // ---------------- stage A: fold angle to a quarter turn ----------------
  logic [FB:0]   frac, u_d, u_q, r_ext;
  logic [FB+2:0] h;
  logic [1:0]    quad;
  logic          neg_d;
  logic          neg_q [ST_A:ST_S];

  assign frac  = dv_one_q[FB] ? ONE : {1'b0, dv_quo_q[FB]};
  assign quad  = h[FB+1:FB];
  assign r_ext = {1'b0, h[FB-1:0]};

  always_comb begin
    case (shape_e'(shape_q))
      SH_FULL: h = {frac, 2'b00};
      SH_HSIN: h = {1'b0, frac, 1'b0} + {2'b00, ONE} + {1'b0, ONE, 1'b0};
      default: h = {1'b0, frac, 1'b0};
    endcase
    case (shape_e'(shape_q))
      SH_QCOS: begin
        u_d   = ONE - frac;
        neg_d = 1'b0;
      end
      SH_QSIN: begin
        u_d   = frac;
        neg_d = 1'b0;
      end
      default: begin
        u_d   = quad[0] ? r_ext : ONE - r_ext;
        neg_d = (quad == 2'd1) || (quad == 2'd2);
      end
    endcase
  end

  // sign travels alongside the sine data up to the final product
  always_ff @(posedge clk_i) begin
    if (en) begin
      u_q <= u_d;
      neg_q[ST_A] <= neg_d;
      for (int k = ST_A + 1; k <= ST_S; k++) neg_q[k] <= neg_q[k-1];
    end
  end

  // ---------------- stage B: square ----------------
  logic [30:0] x30_a;
  logic [61:0] sq;
  logic [30:0] x2_q  [0:3];
  logic [30:0] x30_q [0:4];

  assign x30_a = {u_q, {(30-FB){1'b0}}};
  assign sq    = x30_a * x30_a;

  // ---------------- Horner stages ----------------
  logic [30:0] p_q    [0:3];
  logic [30:0] p_prev [0:3];
  logic [61:0] hp     [0:3];

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      p_prev[k] = (k == 0) ? CE : p_q[(k == 0) ? 0 : k-1];
      hp[k]     = x2_q[k] * p_prev[k];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x2_q[0]  <= sq[60:30];
      x30_q[0] <= x30_a;
      for (int k = 0; k < 4; k++) begin
        p_q[k]     <= COEF[k] - hp[k][60:30];
        x30_q[k+1] <= x30_q[k];
      end
      for (int k = 1; k < 4; k++) x2_q[k] <= x2_q[k-1];
    end
  end

  // ---------------- stage S: final product ----------------
  logic [61:0] sp;
  logic [31:0] s_q;
  assign sp = x30_q[4] * p_q[3];
  always_ff @(posedge clk_i) begin
    if (en) s_q <= sp[61:30];
  end

  // ---------------- stage R: round and form shape numerator ----------------
  logic [31:0]        s_rnd;
  logic [31-(30-FB):0] s_sh;
  logic [FB:0]        sv;
  logic signed [FB+3:0] w, num_s;
  logic [FB+1:0]      num_q;

  assign s_rnd = s_q + (32'd1 << (29 - FB));
  assign s_sh  = s_rnd[31:30-FB];
  assign sv    = (s_sh > {{(31-(30-FB)-FB){1'b0}}, ONE}) ? ONE : s_sh[FB:0];
  assign w     = neg_q[ST_S] ? -$signed({3'b000, sv}) : $signed({3'b000, sv});

  always_comb begin
    case (shape_e'(shape_q))
      SH_FALL: num_s = $signed({3'b000, ONE}) + w;
      SH_QCOS: num_s = $signed({2'b00, ONE, 1'b0}) - $signed({2'b00, sv, 1'b0});
      SH_QSIN: num_s = $signed({2'b00, sv, 1'b0});
      SH_HCOS: num_s = $signed({3'b000, ONE}) - w;
      SH_FULL: num_s = $signed({3'b000, ONE}) - w;
      SH_HSIN: num_s = w <<< 1;
      default: num_s = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) num_q <= num_s[FB+1:0];
  end

  // ---------------- stage M: magnitude multiply ----------------
  logic [31:0]    mabs;
  logic [FB+33:0] prod_q;
  assign mabs = mag_q[31] ? (~mag_q + 32'd1) : mag_q;
  always_ff @(posedge clk_i) begin
    if (en) prod_q <= mabs * num_q;
  end

  // ---------------- output stage ----------------
  logic [FB+33:0] prod_r;
  logic [31:0]    res, val_d, val_q;
  logic           falling_o, rising_o;

  assign prod_r    = prod_q + {{33{1'b0}}, ONE};
  assign res       = prod_r[FB+32:FB+1];
  assign falling_o = shape_q == SH_FALL;
  assign rising_o  = (shape_q == SH_QCOS) || (shape_q == SH_QSIN) || (shape_q == SH_HCOS);

  always_comb begin
    case (ph_q[NST-2])
      PH_BEFORE: val_d = falling_o ? mag_q : '0;
      PH_RAMP:   val_d = mag_q[31] ? (32'd0 - res) : res;
      PH_AFTER:  val_d = rising_o ? mag_q : '0;
      default:   val_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (en) val_q <= val_d;
  end

  assign m_axis_tdata_o = {6'd0, ph_q[NST-1], val_q};

  // ---------------- checks ----------------
  `RCMP_ASSERT(a_bad_shape_zero, m_axis_tvalid_o && (ph_q[NST-1] == PH_BAD) |-> (val_q == '0), "bad shape must give zero")
  `RCMP_ASSERT(a_rise_before_zero, m_axis_tvalid_o && (ph_q[NST-1] == PH_BEFORE) && (shape_q != SH_FALL) |-> (val_q == '0), "rest value before ramp must be zero")
  `RCMP_ASSERT_ALWAYS(a_ready_follows, !rst_ni |-> s_axis_tready_o || m_axis_tready_i, "ready low during reset")

endmodule

// ----- bench/profile_checker.sv -----
// ----------------------------------------------------------------------------
// Profile shaper result checker
// Mirrors the register writes seen on the APB port, predicts one result per
// accepted time stamp and compares each result beat against the oldest one.
// ----------------------------------------------------------------------------
module profile_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [31:0]                 s_tdata_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [39:0]                 m_tdata_i,
  input  logic                        psel_i,
  input  logic                        penable_i,
  input  logic                        pwrite_i,
  input  logic [rcmp_pkg::ADDR_W-1:0] paddr_i,
  input  logic [31:0]                 pwdata_i,
  input  logic                        pready_i,
  output int                          errors_o,
  output int                          pending_o
);
  import rcmp_pkg::*;

  localparam longint unsigned UNIT = 64'd1 << FB;

  typedef struct packed {
    logic [31:0] value;
    phase_e      phase;
  } profile_t;

  logic [2:0]  shape_q;
  logic [31:0] mag_q, start_q;
  logic [19:0] dur_q;
  logic [15:0] lead_q, trail_q;

  profile_t expected_q[$];

  // sine of u quarter turns, Q1.16 in and out
  function automatic longint unsigned quarter_sine(longint unsigned u);
    longint unsigned x30, x2, p, s;
    if (u > UNIT) u = UNIT;
    x30 = u << (30 - FB);
    x2  = (x30 * x30) >> 30;
    p = 64'(CE);
    p = 64'(CD) - ((x2 * p) >> 30);
    p = 64'(CC) - ((x2 * p) >> 30);
    p = 64'(CB) - ((x2 * p) >> 30);
    p = 64'(CA) - ((x2 * p) >> 30);
    s = (x30 * p) >> 30;
    s = (s + (64'd1 << (29 - FB))) >> (30 - FB);
    return (s > UNIT) ? UNIT : s;
  endfunction

  // cosine of h quarter turns, signed Q1.16
  function automatic longint cosine_q(longint unsigned h);
    longint unsigned r;
    h = h % (4 * UNIT);
    r = h & (UNIT - 1);
    case (h >> FB)
      0:       return longint'(quarter_sine(UNIT - r));
      1:       return -longint'(quarter_sine(r));
      2:       return -longint'(quarter_sine(UNIT - r));
      default: return longint'(quarter_sine(r));
    endcase
  endfunction

  // magnitude * num / 2^17, rounded half away from zero
  function automatic logic [31:0] scaled_mag(longint unsigned num);
    logic            neg;
    longint unsigned mabs, res;
    neg  = mag_q[31];
    mabs = neg ? 64'(32'(~mag_q + 32'd1)) : 64'(mag_q);
    if (neg && mabs == 0) mabs = 64'h8000_0000;
    res = (mabs * num + UNIT) >> (FB + 1);
    if (neg) res = 64'd0 - res;
    return res[31:0];
  endfunction

  function automatic profile_t profile_at(logic [31:0] tnow);
    profile_t        r;
    longint          endo, span;
    longint unsigned rel, endo_u, el, f, num;
    logic            early, lt_lead, le_lead, lt_end, le_end, rising, ramp, pre_ramp;
    endo   = longint'(dur_q) - longint'(trail_q);
    span   = endo - longint'(lead_q);
    endo_u = endo;
    early  = tnow < start_q;
    rel    = early ? 0 : 64'(tnow - start_q);
    lt_lead = early || rel < 64'(lead_q);
    le_lead = early || rel <= 64'(lead_q);
    lt_end  = early || (endo > 0 && rel < endo_u);
    le_end  = early || (endo >= 0 && rel <= endo_u);
    rising  = shape_q inside {SH_QCOS, SH_QSIN, SH_HCOS};
    num = 0;
    if (shape_q > SH_HSIN) begin
      r.value = '0;
      r.phase = PH_BAD;
      return r;
    end
    pre_ramp = rising ? lt_lead : le_lead;
    ramp     = (shape_q == SH_FALL || shape_q == SH_HSIN) ? lt_end : le_end;
    if (pre_ramp) begin
      r.phase = PH_BEFORE;
      r.value = (shape_q == SH_FALL) ? mag_q : '0;
    end else if (ramp) begin
      el = rel - 64'(lead_q);
      if (span <= 0 || el >= 64'(span)) f = UNIT;
      else f = (el << FB) / 64'(span);
      if (f > UNIT) f = UNIT;
      case (shape_q)
        SH_FALL: num = longint'(UNIT) + cosine_q(2 * f);
        SH_QCOS: num = 2 * (UNIT - quarter_sine(UNIT - f));
        SH_QSIN: num = 2 * quarter_sine(f);
        SH_HCOS: num = longint'(UNIT) - cosine_q(2 * f);
        SH_FULL: num = longint'(UNIT) - cosine_q(4 * f);
        default: num = 2 * cosine_q(2 * f + 3 * UNIT);
      endcase
      r.phase = PH_RAMP;
      r.value = scaled_mag(num);
    end else begin
      r.phase = PH_AFTER;
      r.value = rising ? mag_q : '0;
    end
    return r;
  endfunction

  // register mirror
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shape_q <= '0; mag_q <= '0; start_q <= '0;
      dur_q <= '0; lead_q <= '0; trail_q <= '0;
    end else if (psel_i && penable_i && pwrite_i && pready_i) begin
      case (paddr_i[ADDR_W-1:2])
        REG_SHAPE: shape_q <= pwdata_i[2:0];
        REG_MAG:   mag_q   <= pwdata_i;
        REG_START: start_q <= pwdata_i;
        REG_DUR:   dur_q   <= pwdata_i[19:0];
        REG_LEAD:  lead_q  <= pwdata_i[15:0];
        REG_TRAIL: trail_q <= pwdata_i[15:0];
        default: ;
      endcase
    end
  end

  initial errors_o = 0;

  always @(posedge clk_i) begin
    profile_t got, want;
    if (rst_ni) begin
      if (s_tvalid_i && s_tready_i) expected_q.push_back(profile_at(s_tdata_i));
      if (m_tvalid_i && m_tready_i) begin
        got.value = m_tdata_i[31:0];
        got.phase = phase_e'(m_tdata_i[33:32]);
        if (expected_q.size() == 0) begin
          errors_o++;
          if (errors_o <= 10) $display("unexpected result beat %h", m_tdata_i);
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.phase !== want.phase) begin
            errors_o++;
            if (errors_o <= 10)
              $display("mismatch: value exp %h got %h, phase exp %0d got %0d",
                       want.value, got.value, want.phase, got.phase);
          end
        end
      end
    end
    pending_o = expected_q.size();
  end
endmodule

// ----- bench/tb.sv -----
// ----------------------------------------------------------------------------
// Profile shaper testbench
// Directed time stamps around every shape's window edges, then random
// register settings and time stamps under changing back-pressure.
// ----------------------------------------------------------------------------
module tb;
  import rcmp_pkg::*;

  logic        clk_i, rst_ni;
  logic        s_tvalid, s_tready, m_tvalid, m_tready;
  logic [31:0] s_tdata;
  logic [39:0] m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  int          errors, pending;

  // back-pressure knobs, percent of cycles
  int          idle_pct, stall_pct;
  logic        hold_off;

  // mirror of the current window, used only to aim time stamps
  logic [31:0] win_start;
  logic [19:0] win_dur;
  logic [15:0] win_lead, win_trail;
  int          beats_sent;

  raised_cosine_motion_profile dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid_i(s_tvalid), .s_axis_tready_o(s_tready), .s_axis_tdata_i(s_tdata),
    .m_axis_tvalid_o(m_tvalid), .m_axis_tready_i(m_tready), .m_axis_tdata_o(m_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .prdata_o(prdata), .pready_o(pready)
  );

  profile_checker chk (
    .clk_i, .rst_ni,
    .s_tvalid_i(s_tvalid), .s_tready_i(s_tready), .s_tdata_i(s_tdata),
    .m_tvalid_i(m_tvalid), .m_tready_i(m_tready), .m_tdata_i(m_tdata),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready), .errors_o(errors), .pending_o(pending)
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  // generous cap on the whole run
  initial begin
    #20_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // result side: random stall, or a long hold when asked
  always @(negedge clk_i) begin
    m_tready <= !hold_off && ($urandom_range(99) >= stall_pct);
  end

  // setup cycle, then access cycle; the write lands at the access edge
  task automatic reg_write(reg_idx_e idx, logic [31:0] v);
    @(negedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
    @(negedge clk_i);
    penable <= 1;
    @(negedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_START: win_start = v;
      REG_DUR:   win_dur   = v[19:0];
      REG_LEAD:  win_lead  = v[15:0];
      REG_TRAIL: win_trail = v[15:0];
      default: ;
    endcase
  endtask

  // one beat; valid stays high into the next beat unless a gap is drawn
  task automatic send_stamp(logic [31:0] t);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 0;
      @(negedge clk_i);
    end
    s_tvalid <= 1;
    s_tdata  <= t;
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
    beats_sent++;
  endtask

  // all results in, and the sender idle, before touching registers
  task automatic drain();
    s_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  // time stamp aimed at the window edges, into the window, at the extremes or at random
  function automatic logic [31:0] aimed_stamp();
    logic [31:0] endo;
    endo = 32'(win_dur) - 32'(win_trail);
    case ($urandom_range(7))
      0:       return $urandom;
      1:       return win_start - 32'($urandom_range(3));
      2:       return win_start + 32'(win_lead) + 32'($urandom_range(2)) - 32'd1;
      3:       return win_start + endo + 32'($urandom_range(2)) - 32'd1;
      4:       return $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
      default: return win_start + 32'($urandom_range(int'(win_dur) + 4));
    endcase
  endfunction

  function automatic logic [31:0] pick_mag();
    case ($urandom_range(5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_delay();
    case ($urandom_range(4))
      0: return 16'h0;
      1: return 16'hFFFF;
      2: return 16'($urandom);
      default: return 16'($urandom_range(40));
    endcase
  endfunction

  initial begin
    rst_ni = 0;
    s_tvalid = 0; s_tdata = '0; m_tready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    idle_pct = 0; stall_pct = 0; hold_off = 0; beats_sent = 0;
    win_start = 0; win_dur = 0; win_lead = 0; win_trail = 0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;

    // directed: a short window, every shape (invalid codes too) at its edges
    reg_write(REG_MAG, 32'h0001_0000);
    reg_write(REG_START, 32'd100);
    reg_write(REG_DUR, 32'd20);
    reg_write(REG_LEAD, 32'd3);
    reg_write(REG_TRAIL, 32'd4);
    for (int sh = 0; sh < 8; sh++) begin
      reg_write(REG_SHAPE, 32'(sh));
      send_stamp(32'd103);
      send_stamp(32'd111);
      send_stamp(32'd116);
      drain();
    end

    // random settings, 30 beats each, rotating the back-pressure mode
    for (int ph = 0; ph < 30; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 63; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 63; end
        default: begin idle_pct = 20; stall_pct = 20; end
      endcase
      reg_write(REG_SHAPE, (ph < 8) ? 32'(ph % 6) : 32'($urandom_range(7)));
      reg_write(REG_MAG, pick_mag());
      case ($urandom_range(3))
        0: reg_write(REG_START, 32'hFFFF_FFFF - 32'($urandom_range(300)));
        1: reg_write(REG_START, 32'h0);
        default: reg_write(REG_START, $urandom);
      endcase
      case ($urandom_range(4))
        0: reg_write(REG_DUR, 32'h0);
        1: reg_write(REG_DUR, 32'hF_FFFF);
        2: reg_write(REG_DUR, 32'($urandom_range(20'hF_FFFF)));
        default: reg_write(REG_DUR, 32'($urandom_range(200)));
      endcase
      reg_write(REG_LEAD, 32'(pick_delay()));
      reg_write(REG_TRAIL, 32'(pick_delay()));
      // one phase: result side held off long enough to back up the input
      if (ph == 4) begin
        fork
          begin
            hold_off = 1;
            repeat (200) @(negedge clk_i);
            hold_off = 0;
          end
        join_none
      end
      for (int i = 0; i < 30; i++) send_stamp(aimed_stamp());
      // sender waits here until every result of the phase is back
      drain();
    end

    $display("Run covered %0d time stamps over all eight shape codes and 30 random windows,",
             beats_sent);
    $display("with idle, stall and long hold-off back-pressure on both streams.");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end
endmodule

// ----- files.f -----
+incdir+src
src/rcmp_pkg.sv
src/raised_cosine_motion_profile.sv
bench/profile_checker.sv
bench/tb.sv
